// ----- design/dwvw_pkg.sv -----
// dwvw_pkg: shared constants, register indexes and controller/datapath types
// for the dwvw audio encoder; no dependencies
package dwvw_pkg;

  localparam int unsigned SAMPLE_W     = 32;  // input sample field width
  localparam int unsigned WS_W         = 6;   // word size register width
  localparam int unsigned MAX_WORD_DEF = 32;  // default widest word size
  localparam int unsigned ADDR_W       = 3;   // two registers at byte 0 and 4
  localparam int unsigned DATA_W       = 32;
  localparam int unsigned BYTE_W       = 8;

  localparam logic [WS_W-1:0] IN_WS_RST  = 6'd16;
  localparam logic [WS_W-1:0] OUT_WS_RST = 6'd16;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_IN_WORD_SIZE  = 1'b0,
    REG_OUT_WORD_SIZE = 1'b1
  } reg_idx_e;

  // datapath step ordered by the controller
  typedef enum logic [3:0] {
    OP_IDLE,
    OP_LOAD,
    OP_SCALE,
    OP_DELTA,
    OP_MAG,
    OP_WIDTH,
    OP_CODE,
    OP_PACK,
    OP_POP
  } op_e;

  typedef struct packed {
    op_e op;
  } cmd_t;

  typedef struct packed {
    logic pack_empty;  // packing step yields no byte (valid during pack)
    logic last_byte;   // one byte left in the output register
  } status_t;

endpackage

// ----- design/dwvw_if.sv -----
// dwvw_if: valid/ready request channels of the dwvw encoder, sample in and
// code byte out; depends on dwvw_pkg
interface dwvw_sample_if import dwvw_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;
  logic                       end_of_channel;

  modport source (output valid, sample, end_of_channel, input ready);
  modport sink (input valid, sample, end_of_channel, output ready);
endinterface

interface dwvw_code_if import dwvw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] code_byte;
  logic              run_last;
  logic              channel_last;

  modport source (output valid, code_byte, run_last, channel_last, input ready);
  modport sink (input valid, code_byte, run_last, channel_last, output ready);
endinterface

// ----- design/dwvw_datapath.sv -----
// dwvw_datapath: rescale, delta, width coding, bit packing and byte output
// register of the dwvw encoder; depends on dwvw_pkg, driven by dwvw_ctrl
module dwvw_datapath import dwvw_pkg::*; #(
  parameter int unsigned MAX_WORD = MAX_WORD_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [WS_W-1:0]     in_word_size_i,
  input  logic [WS_W-1:0]     out_word_size_i,
  input  logic [SAMPLE_W-1:0] sample_i,
  input  logic                end_of_channel_i,
  input  cmd_t                cmd_i,
  output status_t             status_o,
  output logic [BYTE_W-1:0]   code_byte_o,
  output logic                run_last_o,
  output logic                channel_last_o
);

  localparam int unsigned WW    = $clog2(MAX_WORD + 1);        // word size / width
  localparam int unsigned DW    = WW + 1;                      // signed width change
  localparam int unsigned NW    = MAX_WORD + MAX_WORD / 2 + 2; // longest code
  localparam int unsigned LW    = $clog2(NW + 1);
  localparam int unsigned ACC_W = ((NW + 14) / 8) * 8;         // code plus 7 pending
  localparam int unsigned NB    = ACC_W / 8;
  localparam int unsigned NBW   = $clog2(NB + 1);
  localparam int unsigned CW    = $clog2(ACC_W + 1);

  // clamped word sizes
  logic [WW-1:0] iw, ow, half;
  logic [MAX_WORD-1:0] omask;

  always_comb begin
    if (in_word_size_i == '0) begin
      iw = WW'(1);
    end else if (in_word_size_i > WS_W'(MAX_WORD)) begin
      iw = WW'(MAX_WORD);
    end else begin
      iw = in_word_size_i[WW-1:0];
    end
    if (out_word_size_i < WS_W'(2)) begin
      ow = WW'(2);
    end else if (out_word_size_i > WS_W'(MAX_WORD)) begin
      ow = WW'(MAX_WORD);
    end else begin
      ow = out_word_size_i[WW-1:0];
    end
    half  = ow >> 1;
    omask = {MAX_WORD{1'b1}} >> (WW'(MAX_WORD) - ow);
  end

  // history and packing state
  logic [MAX_WORD-1:0] prev_q;
  logic [WW-1:0]       pdw_q;
  logic [6:0]          pend_q;
  logic [2:0]          pc_q;
  logic [NBW-1:0]      nb_q;

  // per item registers
  logic [MAX_WORD-1:0] sample_q, s_q, d_q, mag_q;
  logic                eoc_q, dneg_q, xe_q, xb_q;
  logic [WW-1:0]       w_q, prevw_q;
  logic [NW-1:0]       n_q;
  logic [LW-1:0]       l_q;
  logic [ACC_W-1:0]    acc_q;

  // scale: sign extend from iw and move to ow bits in one shift pair
  logic [MAX_WORD-1:0]        x;
  logic signed [MAX_WORD-1:0] s;

  always_comb begin
    x = sample_q << (WW'(MAX_WORD) - iw);
    s = $signed(x) >>> (WW'(MAX_WORD) - ow);
  end

  // delta wrapped to ow bits
  logic [MAX_WORD-1:0] diff, d, dsh;
  logic                dneg;

  always_comb begin
    diff = s_q - prev_q;
    d    = diff & omask;
    dsh  = d >> (ow - WW'(1));
    dneg = dsh[0];
  end

  // magnitude
  logic [MAX_WORD-1:0] mag;
  assign mag = dneg_q ? ((MAX_WORD'(0) - d_q) & omask) : d_q;

  // bit length of magnitude, most negative delta check
  logic [WW-1:0]       w, prevw;
  logic [MAX_WORD-1:0] rng;
  logic                xe, xb;

  always_comb begin
    w = '0;
    for (int i = 0; i < MAX_WORD; i++) begin
      if (mag_q[i]) begin
        w = WW'(i + 1);
      end
    end
    rng   = omask >> 1;
    xe    = dneg_q && (mag_q >= rng);
    xb    = mag_q > rng;
    prevw = (pdw_q > ow) ? ow : pdw_q;
  end

  // code: unary width change, stop bit, sign, magnitude tail
  logic signed [DW-1:0] dwm_raw, dwm, a_full;
  logic [WW-1:0]        a;
  logic                 sgn, stop, nz;
  logic [1:0]           p;
  logic [LW-1:0]        pl, tl;
  logic [MAX_WORD-1:0]  lowmask;
  logic [MAX_WORD:0]    t_base;
  logic [MAX_WORD+1:0]  t;
  logic [NW-1:0]        n;
  logic [LW-1:0]        l;

  always_comb begin
    dwm_raw = $signed({1'b0, w_q}) - $signed({1'b0, prevw_q});
    if (dwm_raw > $signed({1'b0, half})) begin
      dwm = dwm_raw - $signed({1'b0, ow});
    end else if (dwm_raw < -$signed({1'b0, half})) begin
      dwm = dwm_raw + $signed({1'b0, ow});
    end else begin
      dwm = dwm_raw;
    end
    sgn    = dwm[DW-1];
    a_full = sgn ? -dwm : dwm;
    a      = a_full[WW-1:0];
    stop   = a < half;
    nz     = a != '0;
    if (stop) begin
      p = nz ? {1'b1, sgn} : 2'b01;
    end else begin
      p = {1'b0, sgn};
    end
    pl      = LW'(a) + LW'(stop) + LW'(nz);
    // zero width leaves an all ones mask on a zero magnitude
    lowmask = ~({MAX_WORD{1'b1}} << (w_q - WW'(1)));
    t_base  = {mag_q & lowmask, dneg_q};
    t       = xe_q ? {t_base, xb_q} : {1'b0, t_base};
    tl      = LW'(w_q) + LW'(xe_q);
    n       = (NW'(p) << tl) | NW'(t);
    l       = pl + tl;
  end

  // pack: pending bits then new code, left aligned
  logic [CW-1:0]    cnt;
  logic [ACC_W-1:0] acc, tail;
  logic [2:0]       rem;
  logic [6:0]       pend_next;
  logic [NBW-1:0]   nb;

  always_comb begin
    cnt       = CW'(pc_q) + CW'(l_q);
    acc       = (ACC_W'(pend_q) << (CW'(ACC_W) - CW'(pc_q)))
              | (ACC_W'(n_q) << (CW'(ACC_W) - cnt));
    tail      = (ACC_W'(pend_q) << l_q) | ACC_W'(n_q);
    rem       = cnt[2:0];
    pend_next = tail[6:0] & ~(7'h7f << rem);
    nb        = NBW'(cnt >> 3) + NBW'(eoc_q && (rem != 3'd0));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q <= '0;
      pdw_q  <= '0;
      pend_q <= '0;
      pc_q   <= '0;
      nb_q   <= '0;
    end else begin
      case (cmd_i.op)
        OP_DELTA: begin
          prev_q <= s_q;
        end
        OP_WIDTH: begin
          pdw_q <= w;
        end
        OP_PACK: begin
          nb_q <= nb;
          if (eoc_q) begin
            prev_q <= '0;
            pdw_q  <= '0;
            pend_q <= '0;
            pc_q   <= '0;
          end else begin
            pend_q <= pend_next;
            pc_q   <= rem;
          end
        end
        OP_POP: begin
          nb_q <= nb_q - NBW'(1);
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_LOAD: begin
        sample_q <= sample_i[MAX_WORD-1:0];
        eoc_q    <= end_of_channel_i;
      end
      OP_SCALE: begin
        s_q <= s;
      end
      OP_DELTA: begin
        d_q    <= d;
        dneg_q <= dneg;
      end
      OP_MAG: begin
        mag_q <= mag;
      end
      OP_WIDTH: begin
        w_q     <= w;
        prevw_q <= prevw;
        xe_q    <= xe;
        xb_q    <= xb;
      end
      OP_CODE: begin
        n_q <= n;
        l_q <= l;
      end
      OP_PACK: begin
        acc_q <= acc;
      end
      OP_POP: begin
        acc_q <= acc_q << BYTE_W;
      end
      default: begin
      end
    endcase
  end

  logic last;
  assign last                = nb_q == NBW'(1);
  assign status_o.pack_empty = nb == '0;
  assign status_o.last_byte  = last;
  assign code_byte_o         = acc_q[ACC_W-1 -: BYTE_W];
  assign run_last_o          = last;
  assign channel_last_o      = last & eoc_q;

  // pending bits above the count stay clear
  a_pend_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (7'(pend_q >> pc_q) == 7'd0))
    else $error("pending bits above count are set");

  // a byte is popped only while one is held
  a_pop_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_POP) |-> (nb_q != '0))
    else $error("pop with no byte held");

  // every sample codes at least one bit, so a channel end always yields a byte
  a_eoc_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_PACK && eoc_q) |-> !status_o.pack_empty)
    else $error("channel end packed no byte");

endmodule

// ----- design/dwvw_ctrl.sv -----
// dwvw_ctrl: sequencing state machine of the dwvw encoder, steps the datapath
// and runs both request handshakes; depends on dwvw_pkg
module dwvw_ctrl import dwvw_pkg::*; (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  output logic    out_valid_o,
  input  logic    out_ready_i,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_DELTA,
    ST_MAG,
    ST_WIDTH,
    ST_CODE,
    ST_PACK,
    ST_EMIT
  } state_e;

  state_e state_q;
  logic   ready_q, valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      ready_q <= 1'b1;
      valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            state_q <= ST_SCALE;
            ready_q <= 1'b0;
          end
        end
        ST_SCALE: state_q <= ST_DELTA;
        ST_DELTA: state_q <= ST_MAG;
        ST_MAG:   state_q <= ST_WIDTH;
        ST_WIDTH: state_q <= ST_CODE;
        ST_CODE:  state_q <= ST_PACK;
        ST_PACK: begin
          if (status_i.pack_empty) begin
            state_q <= ST_IDLE;
            ready_q <= 1'b1;
          end else begin
            state_q <= ST_EMIT;
            valid_q <= 1'b1;
          end
        end
        ST_EMIT: begin
          if (out_ready_i && status_i.last_byte) begin
            state_q <= ST_IDLE;
            valid_q <= 1'b0;
            ready_q <= 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
          ready_q <= 1'b1;
          valid_q <= 1'b0;
        end
      endcase
    end
  end

  always_comb begin
    case (state_q)
      ST_IDLE:  cmd_o.op = (in_valid_i && ready_q) ? OP_LOAD : OP_IDLE;
      ST_SCALE: cmd_o.op = OP_SCALE;
      ST_DELTA: cmd_o.op = OP_DELTA;
      ST_MAG:   cmd_o.op = OP_MAG;
      ST_WIDTH: cmd_o.op = OP_WIDTH;
      ST_CODE:  cmd_o.op = OP_CODE;
      ST_PACK:  cmd_o.op = OP_PACK;
      ST_EMIT:  cmd_o.op = (out_ready_i && valid_q) ? OP_POP : OP_IDLE;
      default:  cmd_o.op = OP_IDLE;
    endcase
  end

  assign in_ready_o  = ready_q;
  assign out_valid_o = valid_q;

  // input side and output side never open together
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ready_q && valid_q))
    else $error("ready and valid high together");

  // bytes of one sample leave without a gap in valid
  a_run_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_ready_i && !status_i.last_byte) |=> valid_q)
    else $error("output run broken before last byte");

  // output opens only right after packing
  a_after_pack: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(valid_q) |-> $past(state_q == ST_PACK))
    else $error("output valid rose outside pack");

  // last byte taken returns to accepting
  a_back_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_q && out_ready_i && status_i.last_byte) |=> ready_q)
    else $error("not ready after last byte");

endmodule

// ----- design/dwvw_audio_encoder.sv -----
// dwvw audio encoder. One sample request in gives zero to eight code byte
// requests out, first coded bit in the MSB of each byte. An accepted sample
// steps through the datapath steps (rescale, delta, magnitude, bit length,
// code assembly, packing) in one shared datapath, then one byte leaves per
// cycle while the sink is ready; the next sample is taken in the cycle after
// the last byte. Samples with end_of_channel set flush a partial byte with
// zero padding (channel_last marks that final byte, run_last the last byte
// of every sample) and clear the history. Word sizes are written over the
// APB port at byte 0 (in_word_size) and byte 4 (out_word_size); the user
// must write them only while the block is idle, which the block itself does
// not enforce. Values out of range are clamped when used.
// Depends on dwvw_pkg, dwvw_if, dwvw_ctrl and dwvw_datapath.
module dwvw_audio_encoder import dwvw_pkg::*; #(
  parameter int unsigned MAX_WORD = MAX_WORD_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  // configuration port
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  // sample requests in, code byte requests out
  dwvw_sample_if.sink       sample_i,
  dwvw_code_if.source       code_o
);

  // word size registers
  logic [WS_W-1:0] in_ws_q, out_ws_q;
  logic            cfg_wr;
  reg_idx_e        cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = reg_idx_e'(paddr[2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_ws_q  <= IN_WS_RST;
      out_ws_q <= OUT_WS_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_IN_WORD_SIZE:  in_ws_q  <= pwdata[WS_W-1:0];
        REG_OUT_WORD_SIZE: out_ws_q <= pwdata[WS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    case (cfg_idx)
      REG_IN_WORD_SIZE:  prdata = DATA_W'(in_ws_q);
      REG_OUT_WORD_SIZE: prdata = DATA_W'(out_ws_q);
      default:           prdata = '0;
    endcase
  end

  cmd_t    cmd;
  status_t status;

  // sequencer: one sample at a time, holds both handshakes
  dwvw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (sample_i.valid),
    .in_ready_o  (sample_i.ready),
    .out_valid_o (code_o.valid),
    .out_ready_i (code_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // coding datapath with the byte output register
  dwvw_datapath #(
    .MAX_WORD (MAX_WORD)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_word_size_i   (in_ws_q),
    .out_word_size_i  (out_ws_q),
    .sample_i         (sample_i.sample),
    .end_of_channel_i (sample_i.end_of_channel),
    .cmd_i            (cmd),
    .status_o         (status),
    .code_byte_o      (code_o.code_byte),
    .run_last_o       (code_o.run_last),
    .channel_last_o   (code_o.channel_last)
  );

endmodule
